>>> sv/pic_pkg.sv
package pic_pkg;

	// Controller stage codes.
	typedef logic [2:0] stage_t;
	localparam stage_t STG_ICW1  = 3'd1;
	localparam stage_t STG_ICW2  = 3'd2;
	localparam stage_t STG_ICW3  = 3'd3;
	localparam stage_t STG_ICW4  = 3'd4;
	localparam stage_t STG_READY = 3'd5;

	// Item command codes.
	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_READ  = 2'd0;
	localparam cmd_t CMD_WRITE = 2'd1;
	localparam cmd_t CMD_RAISE = 2'd2;

	// Port select codes.
	localparam logic PORT_CMD  = 1'b0;
	localparam logic PORT_DATA = 1'b1;

	// Command byte fields.
	localparam logic [7:0] CW_INIT     = 8'h10;
	localparam logic [7:0] CW_TYPE     = 8'h18;
	localparam logic [7:0] CW_TYPE_OCW2 = 8'h00;
	localparam logic [7:0] CW_TYPE_OCW3 = 8'h08;
	localparam logic [7:0] CW_EOI      = 8'h20;
	localparam logic [7:0] CW_SPECIFIC = 8'h40;
	localparam logic [7:0] POLL_FLAG   = 8'h80;

	// The line that may replace a pending request.
	localparam logic [2:0] PREEMPT_LINE = 3'd4;

	typedef logic [7:0] byte_t;

endpackage

>>> sv/programmable_interrupt_controller.sv
// An item is taken into the input register, and its result item goes into the output
// register once that register is free or being emptied. Throughput: one item per cycle
// while not stalled; the controller state is updated in the same cycle that the result
// register is loaded, so back-to-back items see each other's effects.
// Reset (arst_n low, asynchronous): both stages empty, initialization restarts at the
// first command word, and all masks, requests and in-service bits are cleared.
module programmable_interrupt_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  pic_pkg::cmd_t       cmd,
	input  logic                port_sel,
	input  pic_pkg::byte_t      write_data,
	input  logic [2:0]          irq_line,
	output logic                out_valid,
	input  logic                out_stall,
	output pic_pkg::byte_t      read_data,
	output logic                core_irq_pulse
);
	import pic_pkg::*;

	// Input register.
	logic       v_s1;
	cmd_t       cmd_s1;
	logic       port_s1;
	byte_t      data_s1;
	logic [2:0] line_s1;

	// Result register.
	logic       v_s2;
	byte_t      rd_s2;
	logic       pulse_s2;

	// Controller state.
	stage_t     stage_q;
	logic       need_icw4_q;
	logic       single_q;
	byte_t      mask_q;
	byte_t      req_q;
	byte_t      isr_q;
	logic [2:0] level_q;
	logic [1:0] rmode_q;
	logic       poll_q;

	stage_t     stage_d;
	logic       need_icw4_d;
	logic       single_d;
	byte_t      mask_d;
	byte_t      req_d;
	byte_t      isr_d;
	logic [2:0] level_d;
	logic [1:0] rmode_d;
	logic       poll_d;
	byte_t      rd_d;
	logic       pulse_d;

	logic       accept;
	logic       advance;
	logic [2:0] first_req;

	// The item in the input register moves on whenever the result register is free or
	// is being emptied in this cycle. The input side stalls only when it cannot move.
	assign advance  = v_s1 && (!v_s2 || !out_stall);
	assign in_stall = v_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign out_valid      = v_s2;
	assign read_data      = rd_s2;
	assign core_irq_pulse = pulse_s2;

	// Lowest numbered pending request; at most one bit is ever set, but the search
	// keeps the poll behavior right for any pattern.
	always_comb begin
		first_req = 3'd0;
		for (int n = 7; n >= 0; n--) begin
			if (req_q[n]) begin
				first_req = 3'(n);
			end
		end
	end

	// One pass over the current item: the next state and its result item.
	always_comb begin
		stage_d     = stage_q;
		need_icw4_d = need_icw4_q;
		single_d    = single_q;
		mask_d      = mask_q;
		req_d       = req_q;
		isr_d       = isr_q;
		level_d     = level_q;
		rmode_d     = rmode_q;
		poll_d      = poll_q;
		rd_d        = '0;
		pulse_d     = 1'b0;
		unique case (cmd_s1)
			CMD_READ: begin
				if (port_s1 == PORT_DATA) begin
					rd_d = mask_q;
				end else if (rmode_q[1]) begin
					rd_d = rmode_q[0] ? isr_q : req_q;
				end else if (poll_q) begin
					// A poll with nothing pending, or with the pending line masked,
					// only disarms the poll and reports the current level.
					poll_d = 1'b0;
					if (req_q != '0 && !mask_q[first_req]) begin
						isr_d[first_req] = 1'b1;
						req_d[first_req] = 1'b0;
						level_d          = first_req;
					end
					rd_d = POLL_FLAG | {5'b0, level_d};
				end
			end
			CMD_WRITE: begin
				if (port_s1 == PORT_DATA) begin
					unique case (stage_q)
						STG_ICW2: begin
							if (single_q) begin
								stage_d = need_icw4_q ? STG_ICW4 : STG_READY;
							end else begin
								stage_d = STG_ICW3;
							end
						end
						STG_ICW3:  stage_d = need_icw4_q ? STG_ICW4 : STG_READY;
						STG_ICW4:  stage_d = STG_READY;
						STG_READY: mask_d  = data_s1;
						default:   ;
					endcase
				end else if (stage_q == STG_ICW1) begin
					if ((data_s1 & CW_INIT) != '0) begin
						stage_d     = STG_ICW2;
						need_icw4_d = data_s1[0];
						single_d    = data_s1[1];
					end
				end else if (stage_q == STG_ICW3 || stage_q == STG_ICW4 ||
						stage_q == STG_READY) begin
					// A command word during the optional words ends initialization
					// and is then taken as an operational command.
					stage_d = STG_READY;
					if ((data_s1 & CW_TYPE) == CW_TYPE_OCW2) begin
						if ((data_s1 & CW_EOI) != '0) begin
							if ((data_s1 & CW_SPECIFIC) != '0) begin
								isr_d[data_s1[2:0]] = 1'b0;
							end else begin
								isr_d[level_q] = 1'b0;
							end
						end
					end else if ((data_s1 & CW_TYPE) == CW_TYPE_OCW3) begin
						rmode_d = data_s1[1:0];
						poll_d  = data_s1[2];
					end
				end
			end
			CMD_RAISE: begin
				if (stage_q == STG_READY && (req_q == '0 || line_s1 == PREEMPT_LINE)) begin
					req_d            = '0;
					req_d[line_s1]   = 1'b1;
					pulse_d          = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Pipeline control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (advance) begin
				v_s1 <= 1'b0;
			end
			if (advance) begin
				v_s2 <= 1'b1;
			end else if (!out_stall) begin
				v_s2 <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd;
			port_s1 <= port_sel;
			data_s1 <= write_data;
			line_s1 <= irq_line;
		end
		if (advance) begin
			rd_s2    <= rd_d;
			pulse_s2 <= pulse_d;
		end
	end

	// Controller state is committed as the item leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q     <= STG_ICW1;
			need_icw4_q <= 1'b0;
			single_q    <= 1'b0;
			mask_q      <= '0;
			req_q       <= '0;
			isr_q       <= '0;
			level_q     <= '0;
			rmode_q     <= '0;
			poll_q      <= 1'b0;
		end else if (advance) begin
			stage_q     <= stage_d;
			need_icw4_q <= need_icw4_d;
			single_q    <= single_d;
			mask_q      <= mask_d;
			req_q       <= req_d;
			isr_q       <= isr_d;
			level_q     <= level_d;
			rmode_q     <= rmode_d;
			poll_q      <= poll_d;
		end
	end

endmodule

>>> sv/pic_checker.sv
module pic_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] read_data,
	input logic       core_irq_pulse
);

	// A result item that is held back stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result item dropped while stalled");

	// A result item that is held back keeps its contents.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(read_data) && $stable(core_irq_pulse))
		else $error("stalled result item changed");

	// A result item is either a read or a raise, never both.
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && core_irq_pulse |-> read_data == 8'h00)
		else $error("raise pulse with nonzero read data");

	// With the output held and an item just taken, the input side must stall next.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall && in_valid && !in_stall ##1 out_stall |-> in_stall)
		else $error("input accepted with both stages full");

endmodule

bind programmable_interrupt_controller pic_checker u_pic_checker (.*);

>>> tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pic_pkg::*;

	// The command field is two bits wide; its fourth value is undefined and must do nothing.
	localparam cmd_t CMD_UNUSED = 2'd3;

	localparam int CLK_PERIOD     = 4;
	localparam int RESET_CYCLES   = 7;
	localparam int N_OPEN         = 25;
	localparam int N_RANDOM       = 1450;
	localparam int IDLE_PCT       = 28;
	localparam int HOLD_CYCLES    = 80;
	localparam int DRAIN_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT = 1000;

	// One row of the opening sequence. When typed is set, the expected result is written
	// into the row; otherwise it comes from the controller prediction.
	typedef struct packed {
		cmd_t       op;
		logic       port;
		byte_t      data;
		logic [2:0] line;
		logic       typed;
		byte_t      rd;
		logic       pulse;
	} stim_row_t;

	typedef struct packed {
		byte_t rd;
		logic  pulse;
	} result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	cmd_t       cmd = CMD_READ;
	logic       port_sel = PORT_CMD;
	byte_t      write_data = '0;
	logic [2:0] irq_line = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	byte_t      read_data;
	logic       core_irq_pulse;

	// Expected result carried alongside the payload for rows with a typed result.
	logic       drv_typed = 1'b0;
	byte_t      drv_rd = '0;
	logic       drv_pulse = 1'b0;

	// Controller state as the testbench sees it, starting from its reset values.
	stage_t     st_stage = STG_ICW1;
	logic       st_need4 = 1'b0;
	logic       st_single = 1'b0;
	byte_t      st_mask = '0;
	byte_t      st_irr = '0;
	byte_t      st_isr = '0;
	logic [2:0] st_level = '0;
	logic [1:0] st_rmode = '0;
	logic       st_poll = 1'b0;

	result_t     owed_results[$];
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned raises_taken = 0;
	int unsigned polls_served = 0;
	int unsigned errors = 0;

	// Phase controls shared between the sender and the receiver.
	logic steady = 1'b0;
	logic want_hold = 1'b0;
	logic hold_done = 1'b0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	programmable_interrupt_controller dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.port_sel      (port_sel),
		.write_data    (write_data),
		.irq_line      (irq_line),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.read_data     (read_data),
		.core_irq_pulse(core_irq_pulse)
	);

	// Applies one item to the controller state and returns the result it should produce.
	task automatic advance_controller(input cmd_t op, input logic port, input byte_t d,
			input logic [2:0] line, output byte_t rd, output logic pulse);
		int n;
		rd = '0;
		pulse = 1'b0;
		case (op)
			CMD_READ: begin
				if (port == PORT_DATA) begin
					rd = st_mask;
				end else if (st_rmode[1]) begin
					// A selected read register takes priority over an armed poll.
					rd = st_rmode[0] ? st_isr : st_irr;
				end else if (st_poll) begin
					// A poll disarms itself. The lowest pending line moves into service
					// unless it is masked; with nothing pending nothing moves.
					st_poll = 1'b0;
					polls_served++;
					if (st_irr != '0) begin
						n = 0;
						while (!st_irr[n]) n++;
						if (!st_mask[n]) begin
							st_isr[n] = 1'b1;
							st_irr[n] = 1'b0;
							st_level = n[2:0];
						end
					end
					rd = POLL_FLAG | {5'b0, st_level};
				end
			end
			CMD_WRITE: begin
				if (port == PORT_DATA) begin
					// Data port: initialization words advance the sequence and are not
					// kept; once running, the byte is the mask.
					case (st_stage)
						STG_ICW2: begin
							if (st_single)
								st_stage = st_need4 ? STG_ICW4 : STG_READY;
							else
								st_stage = STG_ICW3;
						end
						STG_ICW3: st_stage = st_need4 ? STG_ICW4 : STG_READY;
						STG_ICW4: st_stage = STG_READY;
						STG_READY: st_mask = d;
						default: ;
					endcase
				end else if (st_stage == STG_ICW1) begin
					if ((d & CW_INIT) != '0) begin
						st_stage = STG_ICW2;
						st_need4 = d[0];
						st_single = d[1];
					end
				end else begin
					// A command byte cuts short the optional words and is then handled
					// as an operational command; while the second word is awaited it
					// is dropped.
					if (st_stage == STG_ICW3 || st_stage == STG_ICW4)
						st_stage = STG_READY;
					if (st_stage == STG_READY) begin
						if ((d & CW_TYPE) == CW_TYPE_OCW2) begin
							if ((d & CW_EOI) != '0) begin
								if ((d & CW_SPECIFIC) != '0)
									st_isr[d[2:0]] = 1'b0;
								else
									st_isr[st_level] = 1'b0;
							end
						end else if ((d & CW_TYPE) == CW_TYPE_OCW3) begin
							st_rmode = d[1:0];
							st_poll = d[2];
						end
					end
				end
			end
			CMD_RAISE: begin
				// One request is held at a time; only the preempting line replaces it.
				if (st_stage == STG_READY && (st_irr == '0 || line == PREEMPT_LINE)) begin
					st_irr = 8'b1 << line;
					pulse = 1'b1;
				end
			end
			default: ;
		endcase
	endtask

	// Offers one item, idling at random first, and returns once the block has taken it.
	// The payload is held unchanged while the block stalls.
	task automatic offer_item(input cmd_t op, input logic port, input byte_t d,
			input logic [2:0] line, input logic typed = 1'b0, input byte_t rd = '0,
			input logic pulse = 1'b0);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		port_sel <= port;
		write_data <= d;
		irq_line <= line;
		drv_typed <= typed;
		drv_rd <= rd;
		drv_pulse <= pulse;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	// Input and output handshakes are both sampled at the rising edge. Every accepted item
	// owes exactly one result, so the expectations form a plain in-order queue.
	always @(posedge clk) begin : scoreboard
		byte_t   rd;
		logic    pl;
		result_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				advance_controller(cmd, port_sel, write_data, irq_line, rd, pl);
				if (drv_typed) begin
					rd = drv_rd;
					pl = drv_pulse;
				end
				if (pl)
					raises_taken++;
				want.rd = rd;
				want.pulse = pl;
				owed_results.push_back(want);
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (owed_results.size() == 0) begin
					$display("%0t: result with none expected, read_data 0x%02h pulse %0b",
						$time, read_data, core_irq_pulse);
					errors++;
				end else begin
					want = owed_results.pop_front();
					if (read_data !== want.rd) begin
						$display("%0t: read_data expected 0x%02h, got 0x%02h",
							$time, want.rd, read_data);
						errors++;
					end
					if (core_irq_pulse !== want.pulse) begin
						$display("%0t: core_irq_pulse expected %0b, got %0b",
							$time, want.pulse, core_irq_pulse);
						errors++;
					end
				end
			end
		end
	end

	// The receiver stalls at random, not at all during the steady phase, and once holds
	// off for a long stretch so that the block backs up into its input.
	initial begin : receiver
		forever begin
			@(posedge clk);
			if (want_hold && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (steady) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Ends the run if no item moves on either side for too long.
	initial begin : watchdog
		int unsigned stuck;
		stuck = 0;
		while (stuck < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				stuck = 0;
			else
				stuck++;
		end
		$display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin : stimulus
		stim_row_t   opening [N_OPEN];
		int unsigned r;
		int unsigned kind;
		logic        paused;

		// The opening sequence walks the initialization path in cascade mode with the
		// fourth word requested, cuts it short with a command byte, and then visits
		// requests, polls, end of interrupt, masking and the undefined command.
		opening = '{
			// Straight after reset every read is zero and a raise is dropped.
			'{CMD_READ,   PORT_CMD,  8'h00, 3'd0, 1'b1, 8'h00, 1'b0},
			'{CMD_READ,   PORT_DATA, 8'h00, 3'd0, 1'b1, 8'h00, 1'b0},
			'{CMD_RAISE,  PORT_CMD,  8'h00, 3'd7, 1'b1, 8'h00, 1'b0},
			// A command byte without the init bit and a data byte are ignored here.
			'{CMD_WRITE,  PORT_CMD,  8'hEF, 3'd0, 1'b0, 8'h00, 1'b0},
			'{CMD_WRITE,  PORT_DATA, 8'hFF, 3'd7, 1'b0, 8'h00, 1'b0},
			'{CMD_WRITE,  PORT_CMD,  8'h11, 3'd0, 1'b0, 8'h00, 1'b0},
			// A command byte is dropped while the second word is awaited.
			'{CMD_WRITE,  PORT_CMD,  8'hFF, 3'd0, 1'b0, 8'h00, 1'b0},
			'{CMD_WRITE,  PORT_DATA, 8'hA5, 3'd0, 1'b0, 8'h00, 1'b0},
			'{CMD_WRITE,  PORT_DATA, 8'h5A, 3'd0, 1'b0, 8'h00, 1'b0},
			// The fourth word is skipped: this command ends initialization and selects
			// the request register for reading.
			'{CMD_WRITE,  PORT_CMD,  8'h0A, 3'd0, 1'b0, 8'h00, 1'b0},
			'{CMD_RAISE,  PORT_CMD,  8'h00, 3'd0, 1'b1, 8'h00, 1'b1},
			'{CMD_RAISE,  PORT_DATA, 8'h00, 3'd3, 1'b1, 8'h00, 1'b0},
			'{CMD_READ,   PORT_CMD,  8'h00, 3'd0, 1'b0, 8'h00, 1'b0},
			// The preempting line replaces a pending request.
			'{CMD_RAISE,  PORT_CMD,  8'h00, 3'd4, 1'b1, 8'h00, 1'b1},
			'{CMD_WRITE,  PORT_CMD,  8'h0C, 3'd0, 1'b0, 8'h00, 1'b0},
			'{CMD_READ,   PORT_CMD,  8'h00, 3'd0, 1'b0, 8'h00, 1'b0},
			'{CMD_WRITE,  PORT_CMD,  8'h64, 3'd0, 1'b0, 8'h00, 1'b0},
			// Second command word without the end-of-interrupt bit.
			'{CMD_WRITE,  PORT_CMD,  8'h40, 3'd0, 1'b0, 8'h00, 1'b0},
			// The init bit no longer restarts initialization.
			'{CMD_WRITE,  PORT_CMD,  8'h1F, 3'd0, 1'b0, 8'h00, 1'b0},
			'{CMD_WRITE,  PORT_DATA, 8'hFF, 3'd0, 1'b0, 8'h00, 1'b0},
			'{CMD_READ,   PORT_DATA, 8'h00, 3'd0, 1'b1, 8'hFF, 1'b0},
			'{CMD_RAISE,  PORT_CMD,  8'h00, 3'd2, 1'b1, 8'h00, 1'b1},
			// Poll with the pending line masked: it stays pending.
			'{CMD_WRITE,  PORT_CMD,  8'h0C, 3'd0, 1'b0, 8'h00, 1'b0},
			'{CMD_READ,   PORT_CMD,  8'h00, 3'd0, 1'b0, 8'h00, 1'b0},
			// The undefined command does nothing whatever the other fields hold.
			'{CMD_UNUSED, PORT_DATA, 8'hFF, 3'd7, 1'b1, 8'h00, 1'b0}
		};
		paused = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		foreach (opening[i])
			offer_item(opening[i].op, opening[i].port, opening[i].data, opening[i].line,
				opening[i].typed, opening[i].rd, opening[i].pulse);

		// The random part is built mostly from short well-formed sequences: raise then
		// poll, select a register then read it, end of interrupt, mask updates. A share
		// of items is pure noise over every field.
		while (items_sent < N_OPEN + N_RANDOM) begin
			steady = (items_sent >= 300 && items_sent < 500);
			if (items_sent >= 700)
				want_hold = 1'b1;
			if (items_sent >= 1000 && !paused) begin
				// Let the block drain completely before going on.
				paused = 1'b1;
				in_valid <= 1'b0;
				@(posedge clk);
				while (owed_results.size() != 0) @(posedge clk);
			end
			r = $urandom();
			kind = $urandom_range(99);
			if (kind < 30) begin
				offer_item(CMD_RAISE, r[16], r[31:24], r[19:17]);
				if (r[20]) begin
					offer_item(CMD_WRITE, PORT_CMD, {r[7:5], 2'b01, 1'b1, 1'b0, r[8]},
						r[23:21]);
					offer_item(CMD_READ, PORT_CMD, r[31:24], r[26:24]);
				end
			end else if (kind < 50) begin
				offer_item(CMD_WRITE, PORT_CMD, {r[7:5], 2'b01, r[9], 1'b1, r[10]},
					r[19:17]);
				offer_item(CMD_READ, r[11] & r[12], r[31:24], r[22:20]);
			end else if (kind < 68) begin
				offer_item(CMD_WRITE, PORT_CMD,
					{r[11], r[12], ~(r[13] & r[14]), 2'b00, r[2:0]}, r[19:17]);
			end else if (kind < 80) begin
				offer_item(CMD_WRITE, PORT_DATA, r[15] ? r[31:24] : 8'h00, r[19:17]);
			end else if (kind < 88) begin
				offer_item(CMD_READ, r[16], r[31:24], r[19:17]);
			end else begin
				offer_item(cmd_t'(r[1:0]), r[16], r[31:24], r[19:17]);
			end
		end
		in_valid <= 1'b0;
		steady = 1'b0;

		while (owed_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d items and %0d results: initialization, %0d raises taken,",
			items_sent, results_seen, raises_taken);
		$display("%0d poll reads, masks, end of interrupt, a long output hold-off and a drain.",
			polls_served);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> files.f
sv/pic_pkg.sv
sv/programmable_interrupt_controller.sv
sv/pic_checker.sv
tb/testbench.sv
